[rtl/core/bed_pkg.sv]
// Shared types and constants of the backslash escape decoder.
// Holds the request structs of both queue sides and the per-item result group.
// No dependencies.
package bed_pkg;

	// Most result bytes one input byte can cause (a four-byte UTF-8 sequence)
	localparam int MAX_RESULTS = 4;
	localparam int GRP_IDX_W   = $clog2(MAX_RESULTS);

	// Default depth of the group queue between front and back
	localparam int QUEUE_DEPTH = 2;

	// Input request
	typedef struct packed {
		logic [7:0] in_byte;
		logic       string_end;
	} in_item_t;

	// Result request
	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_valid;
		logic       run_end;
		logic       string_done;
		logic       error;
	} out_item_t;

	// One result slot of a group
	typedef struct packed {
		logic [7:0] data;
		logic       valid;
		logic       err;
	} ent_t;

	// All results caused by one input byte
	typedef struct packed {
		ent_t [MAX_RESULTS-1:0]  ent;
		logic [GRP_IDX_W-1:0]    last_idx;
		logic                    done;
	} group_t;

endpackage

[rtl/core/bed_front.sv]
// Front end of the escape decoder: accepts input bytes, tracks the escape
// phase and builds the group of results each byte causes.
// Depends on bed_pkg.
module bed_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_wdata,
	input  logic              push,
	input  bed_pkg::in_item_t item,
	input  logic              q_full,
	output logic              q_push,
	output bed_pkg::group_t   q_data
);

	typedef enum logic [2:0] {
		PH_NORMAL,
		PH_AFTER_BS,
		PH_WS_SKIP,
		PH_HEX,
		PH_OCT,
		PH_UNI4,
		PH_UNI8,
		PH_DROP
	} phase_t;

	localparam logic [7:0] CH_BSL = 8'h5C;
	localparam logic [7:0] CH_NL  = 8'h0A;
	localparam logic [7:0] CH_SP  = 8'h20;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_0   = 8'h30;
	localparam logic [7:0] CH_7   = 8'h37;
	localparam logic [7:0] CH_9   = 8'h39;
	localparam logic [7:0] CH_LA  = 8'h61;
	localparam logic [7:0] CH_LB  = 8'h62;
	localparam logic [7:0] CH_LF  = 8'h66;
	localparam logic [7:0] CH_LN  = 8'h6E;
	localparam logic [7:0] CH_LR  = 8'h72;
	localparam logic [7:0] CH_LT  = 8'h74;
	localparam logic [7:0] CH_LV  = 8'h76;
	localparam logic [7:0] CH_LX  = 8'h78;
	localparam logic [7:0] CH_LU  = 8'h75;
	localparam logic [7:0] CH_UA  = 8'h41;
	localparam logic [7:0] CH_UF  = 8'h46;
	localparam logic [7:0] CH_UU  = 8'h55;

	localparam logic [31:0] CP_MAX  = 32'h0010_FFFF;
	localparam logic [31:0] CP_REPL = 32'h0000_FFFD;

	localparam int CNT_W = 3;

	// Decode a hex digit: {valid, value}
	function automatic logic [4:0] hex_val(input logic [7:0] c);
		logic [4:0] r;
		r = '0;
		if (c >= CH_0 && c <= CH_9) begin
			r = {1'b1, c[3:0]};
		end else if ((c >= CH_LA && c <= CH_LF) || (c >= CH_UA && c <= CH_UF)) begin
			r = {1'b1, 4'(c[3:0] + 4'd9)};
		end
		return r;
	endfunction

	phase_t      ph_q, ph_d;
	logic [31:0] acc_q, acc_d;
	logic [3:0]  cnt_q, cnt_d;
	logic        en_q;
	logic        accept;

	bed_pkg::ent_t [bed_pkg::MAX_RESULTS-1:0] ents;
	logic [CNT_W-1:0] n;

	assign accept = push && !q_full;

	// Next phase and result group for the current byte
	always_comb begin
		logic [7:0]  c;
		logic [4:0]  hx;
		logic        do_plain;
		logic [3:0]  cnt_n;
		logic [31:0] acc_n;
		logic [31:0] cp;
		logic        need_done;

		c         = item.in_byte;
		hx        = hex_val(c);
		do_plain  = 1'b0;
		cnt_n     = cnt_q + 4'd1;
		acc_n     = acc_q;
		cp        = '0;
		need_done = 1'b0;
		ents      = '0;
		n         = '0;
		ph_d      = ph_q;
		acc_d     = acc_q;
		cnt_d     = cnt_q;

		unique case (ph_q)
			PH_NORMAL: begin
				do_plain = 1'b1;
			end
			PH_AFTER_BS: begin
				acc_d = '0;
				cnt_d = '0;
				ph_d  = PH_NORMAL;
				unique case (c)
					CH_LA: begin ents[0] = '{8'h07, 1'b1, 1'b0}; n = 3'd1; end
					CH_LB: begin ents[0] = '{8'h08, 1'b1, 1'b0}; n = 3'd1; end
					CH_LF: begin ents[0] = '{8'h0C, 1'b1, 1'b0}; n = 3'd1; end
					CH_LN: begin ents[0] = '{8'h0A, 1'b1, 1'b0}; n = 3'd1; end
					CH_LR: begin ents[0] = '{8'h0D, 1'b1, 1'b0}; n = 3'd1; end
					CH_LT: begin ents[0] = '{8'h09, 1'b1, 1'b0}; n = 3'd1; end
					CH_LV: begin ents[0] = '{8'h0B, 1'b1, 1'b0}; n = 3'd1; end
					CH_NL: begin
						ents[0] = '{CH_SP, 1'b1, 1'b0};
						n       = 3'd1;
						ph_d    = PH_WS_SKIP;
					end
					CH_LX: ph_d = PH_HEX;
					CH_LU: ph_d = PH_UNI4;
					CH_UU: ph_d = PH_UNI8;
					default: begin
						if (c >= CH_0 && c <= CH_7) begin
							acc_d = {29'd0, c[2:0]};
							cnt_d = 4'd1;
							ph_d  = PH_OCT;
						end else begin
							ents[0] = '{c, 1'b1, 1'b0};
							n       = 3'd1;
						end
					end
				endcase
			end
			PH_WS_SKIP: begin
				if (c != CH_SP && c != CH_TAB) begin
					ph_d     = PH_NORMAL;
					do_plain = 1'b1;
				end
			end
			PH_HEX: begin
				if (hx[4]) begin
					acc_d = {24'd0, acc_q[3:0], hx[3:0]};
					cnt_d = cnt_n;
					if (cnt_n >= 4'd2) begin
						ents[0] = '{acc_d[7:0], 1'b1, 1'b0};
						n       = 3'd1;
						ph_d    = PH_NORMAL;
					end
				end else begin
					ents[0]  = '{(cnt_q != 4'd0) ? acc_q[7:0] : CH_LX, 1'b1, 1'b0};
					n        = 3'd1;
					ph_d     = PH_NORMAL;
					do_plain = 1'b1;
				end
			end
			PH_OCT: begin
				if (c >= CH_0 && c <= CH_7) begin
					acc_d = {23'd0, acc_q[5:0], c[2:0]};
					cnt_d = cnt_n;
					if (cnt_n >= 4'd3) begin
						ents[0] = '{acc_d[7:0], 1'b1, 1'b0};
						n       = 3'd1;
						ph_d    = PH_NORMAL;
					end
				end else begin
					ents[0]  = '{acc_q[7:0], 1'b1, 1'b0};
					n        = 3'd1;
					ph_d     = PH_NORMAL;
					do_plain = 1'b1;
				end
			end
			PH_UNI4, PH_UNI8: begin
				if (hx[4]) begin
					acc_n     = {acc_q[27:0], hx[3:0]};
					acc_d     = acc_n;
					cnt_d     = cnt_n;
					need_done = (ph_q == PH_UNI4) ? (cnt_n >= 4'd4) : (cnt_n >= 4'd8);
					if (need_done) begin
						// Encode the code point as UTF-8, replacing out-of-range values
						cp   = (acc_n > CP_MAX) ? CP_REPL : acc_n;
						ph_d = PH_NORMAL;
						if (cp < 32'h80) begin
							ents[0] = '{cp[7:0], 1'b1, 1'b0};
							n       = 3'd1;
						end else if (cp < 32'h800) begin
							ents[0] = '{{3'b110, cp[10:6]}, 1'b1, 1'b0};
							ents[1] = '{{2'b10, cp[5:0]}, 1'b1, 1'b0};
							n       = 3'd2;
						end else if (cp < 32'h1_0000) begin
							ents[0] = '{{4'b1110, cp[15:12]}, 1'b1, 1'b0};
							ents[1] = '{{2'b10, cp[11:6]}, 1'b1, 1'b0};
							ents[2] = '{{2'b10, cp[5:0]}, 1'b1, 1'b0};
							n       = 3'd3;
						end else begin
							ents[0] = '{{5'b11110, cp[20:18]}, 1'b1, 1'b0};
							ents[1] = '{{2'b10, cp[17:12]}, 1'b1, 1'b0};
							ents[2] = '{{2'b10, cp[11:6]}, 1'b1, 1'b0};
							ents[3] = '{{2'b10, cp[5:0]}, 1'b1, 1'b0};
							n       = 3'd4;
						end
					end
				end else begin
					ents[0] = '{8'h00, 1'b0, 1'b1};
					n       = 3'd1;
					ph_d    = PH_DROP;
				end
			end
			PH_DROP: begin
				ph_d = PH_DROP;
			end
		endcase

		// Handle the byte as ordinary text, possibly opening an escape
		if (do_plain) begin
			if (c == CH_BSL && en_q) begin
				ph_d = PH_AFTER_BS;
			end else begin
				ents[n[1:0]] = '{c, 1'b1, 1'b0};
				n            = n + 3'd1;
			end
		end

		// Flush a pending escape at the end of the string
		if (item.string_end) begin
			unique case (ph_d)
				PH_AFTER_BS: begin
					ents[n[1:0]] = '{CH_BSL, 1'b1, 1'b0};
					n            = n + 3'd1;
				end
				PH_HEX: begin
					ents[n[1:0]] = '{(cnt_d != 4'd0) ? acc_d[7:0] : CH_LX, 1'b1, 1'b0};
					n            = n + 3'd1;
				end
				PH_OCT: begin
					ents[n[1:0]] = '{acc_d[7:0], 1'b1, 1'b0};
					n            = n + 3'd1;
				end
				PH_UNI4, PH_UNI8: begin
					ents[n[1:0]] = '{8'h00, 1'b0, 1'b1};
					n            = n + 3'd1;
				end
				PH_DROP: begin
					if (n == 3'd0) begin
						ents[0] = '{8'h00, 1'b0, 1'b1};
						n       = 3'd1;
					end
				end
				default: begin
				end
			endcase
			if (n == 3'd0) begin
				ents[0] = '{8'h00, 1'b0, 1'b0};
				n       = 3'd1;
			end
			ph_d  = PH_NORMAL;
			acc_d = '0;
			cnt_d = '0;
		end
	end

	// Hand the group to the queue
	assign q_push          = accept && (n != 3'd0);
	assign q_data.ent      = ents;
	assign q_data.last_idx = bed_pkg::GRP_IDX_W'(n - 3'd1);
	assign q_data.done     = item.string_end;

	// Hold phase, accumulator and the enable register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q  <= PH_NORMAL;
			acc_q <= '0;
			cnt_q <= '0;
			en_q  <= 1'b1;
		end else begin
			if (cfg_we) begin
				en_q <= cfg_wdata;
			end
			if (accept) begin
				ph_q  <= ph_d;
				acc_q <= acc_d;
				cnt_q <= cnt_d;
			end
		end
	end

endmodule

[rtl/core/bed_queue.sv]
// Short queue of result groups between the decoder front and back ends.
// Depends on bed_pkg.
module bed_queue #(
	parameter int Depth = bed_pkg::QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_en,
	input  bed_pkg::group_t wr_data,
	output logic            full,
	input  logic            rd_en,
	output bed_pkg::group_t rd_data,
	output logic            empty
);

	localparam int PTR_W = $clog2(Depth);
	localparam int CNT_W = $clog2(Depth + 1);

	bed_pkg::group_t mem [Depth];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;

	assign full    = (cnt_q == CNT_W'(Depth));
	assign empty   = (cnt_q == '0);
	assign rd_data = mem[rd_q];

	// Store written groups
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_q] <= wr_data;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_en) begin
				wr_q <= (wr_q == PTR_W'(Depth - 1)) ? '0 : wr_q + PTR_W'(1);
			end
			if (rd_en) begin
				rd_q <= (rd_q == PTR_W'(Depth - 1)) ? '0 : rd_q + PTR_W'(1);
			end
			if (wr_en && !rd_en) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (rd_en && !wr_en) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

endmodule

[rtl/core/bed_back.sv]
// Back end of the escape decoder: walks each queued group into the output register,
// one result a cycle while the output slot is free or being popped. Depends on bed_pkg.
module bed_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_empty,
	input  bed_pkg::group_t    q_data,
	output logic               q_pop,
	input  logic               pop,
	output logic               empty,
	output bed_pkg::out_item_t result
);

	logic [bed_pkg::GRP_IDX_W-1:0] idx_q;
	logic                          out_valid_q;
	bed_pkg::out_item_t            out_q;
	bed_pkg::ent_t                 ent;
	logic                          load;
	logic                          grp_end;

	assign ent     = q_data.ent[idx_q];
	assign grp_end = (idx_q == q_data.last_idx);
	assign load    = !q_empty && (!out_valid_q || pop);
	assign q_pop   = load && grp_end;
	assign empty   = !out_valid_q;
	assign result  = out_q;

	// Load the next result whenever the output slot frees up
	always_ff @(posedge clk) begin
		if (load) begin
			out_q.data_byte   <= ent.data;
			out_q.byte_valid  <= ent.valid;
			out_q.error       <= ent.err;
			out_q.run_end     <= grp_end;
			out_q.string_done <= grp_end && q_data.done;
		end
	end

	// Advance within the group and track the output slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q <= grp_end ? '0 : idx_q + bed_pkg::GRP_IDX_W'(1);
			end
			out_valid_q <= load || (out_valid_q && !pop);
		end
	end

endmodule

[rtl/core/backslash_escape_decoder_top.sv]
// Backslash escape decoder, top level. Uses bed_pkg, bed_front, bed_queue, bed_back.
// Path: the results of a byte are written as one group into the group queue and then
// leave in order through the back end's output register.
// Throughput: one byte per cycle while the group queue is not full; the back end drains
// one result a cycle while the output is popped; the group queue absorbs short bursts.
// Reset: arst_n clears phase, queue and output slot, and sets the escape enable en_q to 1.
module backslash_escape_decoder_top #(
	parameter int QueueDepth = bed_pkg::QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_wdata,
	input  logic               push,
	output logic               full,
	input  bed_pkg::in_item_t  item,
	output logic               empty,
	input  logic               pop,
	output bed_pkg::out_item_t result
);

	logic            q_push, q_full, q_pop, q_empty;
	bed_pkg::group_t q_wdata, q_rdata;

	assign full = q_full;

	// Classify incoming bytes
	bed_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.push      (push),
		.item      (item),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_data    (q_wdata)
	);

	// Decouple front and back
	bed_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_push),
		.wr_data (q_wdata),
		.full    (q_full),
		.rd_en   (q_pop),
		.rd_data (q_rdata),
		.empty   (q_empty)
	);

	// Emit results one at a time
	bed_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_data  (q_rdata),
		.q_pop   (q_pop),
		.pop     (pop),
		.empty   (empty),
		.result  (result)
	);

`ifndef SYNTH
	a_queue_flags : assert property (@(posedge clk) disable iff (!arst_n)
		!(q_full && q_empty))
		else $error("group queue reports full and empty together");

	a_error_no_byte : assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.error) |-> !result.byte_valid)
		else $error("error request carries a byte");

	a_done_ends_run : assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.string_done) |-> result.run_end)
		else $error("string end request not last of its run");

	a_pop_from_queue : assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("back end drained an empty queue");
`endif

endmodule

[tb/tb_top.sv]
// Self-checking testbench for backslash_escape_decoder_top: byte strings go in through
// the request queue; each result is checked against a byte-level decode model or, for
// typed rows, the given result. Depends on bed_pkg and the decoder RTL.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES  = 6;
	localparam int MAX_REPORTS    = 10;
	localparam int PHASE_ITEMS    = 71;
	localparam int NUM_PHASES     = 4;

	// escape setting per random phase, bit p for phase p
	localparam logic [NUM_PHASES-1:0] PHASE_ESC = 4'b1101;

	localparam logic [7:0]  CH_BS   = 8'h5C;
	localparam logic [7:0]  CH_NL   = 8'h0A;
	localparam logic [7:0]  CH_TAB  = 8'h09;
	localparam logic [7:0]  CH_SP   = 8'h20;
	localparam logic [7:0]  CH_X    = 8'h78;
	localparam logic [7:0]  CH_ZERO = 8'h30;
	localparam logic [55:0] CTRL_LETTERS = "abfnrtv";
	localparam logic [63:0] BIG_CP_DIGITS = "00110000";

	typedef enum logic [2:0] {
		DP_NORMAL, DP_AFTER_BS, DP_WS_SKIP, DP_HEX, DP_OCT, DP_UNI4, DP_UNI8, DP_DROP
	} dec_phase_t;

	typedef struct packed {
		bed_pkg::in_item_t  req;
		logic               typed;
		bed_pkg::out_item_t want;
	} stim_row_t;

	localparam bed_pkg::out_item_t NO_RESULT = '0;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_we = 1'b0;
	logic       cfg_wdata = 1'b0;
	logic       push = 1'b0;
	logic       full;
	bed_pkg::in_item_t  item = '0;
	logic       empty;
	logic       pop = 1'b0;
	bed_pkg::out_item_t result;

	// decode model state
	logic       esc_en = 1'b1;
	dec_phase_t dec_ph = DP_NORMAL;
	logic [31:0] dec_acc = '0;
	logic [3:0] dec_cnt = '0;
	bed_pkg::out_item_t step_q[$];
	bed_pkg::out_item_t pending[$];

	// stimulus and bookkeeping
	logic [7:0] string_bytes[$];
	stim_row_t  dir_rows[$];
	logic       tx_active = 1'b0;
	logic       tx_gaps = 1'b1;
	int         burst_left = 1;
	logic       rx_random = 1'b1;
	logic [15:0] rx_pattern = '1;
	logic [3:0] rx_pos = '0;
	int         idle_cycles = 0;
	int         mismatches = 0;
	int         results_seen = 0;
	int         items_sent = 0;
	int         strings_sent = 0;
	int         cfg_writes = 0;

	backslash_escape_decoder_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.push      (push),
		.full      (full),
		.item      (item),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);

	always #5 clk = ~clk;

	// ---------------------------------------------------------------- decode model

	function automatic int hex_value(logic [7:0] c);
		if (c >= "0" && c <= "9") return int'(c - CH_ZERO);
		if (c >= "a" && c <= "f") return int'(c - 8'h57);
		if (c >= "A" && c <= "F") return int'(c - 8'h37);
		return -1;
	endfunction

	task automatic emit(input logic [7:0] b, input logic v, input logic e);
		bed_pkg::out_item_t r;
		r = '0;
		r.data_byte = v ? b : 8'h00;
		r.byte_valid = v;
		r.error = e;
		step_q.push_back(r);
	endtask

	task automatic emit_utf8(input logic [31:0] code);
		logic [31:0] cp;
		cp = (code > 32'h10FFFF) ? 32'hFFFD : code;
		if (cp < 32'h80) begin
			emit(cp[7:0], 1'b1, 1'b0);
		end else if (cp < 32'h800) begin
			emit({3'b110, cp[10:6]}, 1'b1, 1'b0);
			emit({2'b10, cp[5:0]}, 1'b1, 1'b0);
		end else if (cp < 32'h10000) begin
			emit({4'b1110, cp[15:12]}, 1'b1, 1'b0);
			emit({2'b10, cp[11:6]}, 1'b1, 1'b0);
			emit({2'b10, cp[5:0]}, 1'b1, 1'b0);
		end else begin
			emit({5'b11110, cp[20:18]}, 1'b1, 1'b0);
			emit({2'b10, cp[17:12]}, 1'b1, 1'b0);
			emit({2'b10, cp[11:6]}, 1'b1, 1'b0);
			emit({2'b10, cp[5:0]}, 1'b1, 1'b0);
		end
	endtask

	// A backslash opens an escape only while escapes are on
	task automatic take_plain(input logic [7:0] c);
		if (c == CH_BS && esc_en) dec_ph = DP_AFTER_BS;
		else emit(c, 1'b1, 1'b0);
	endtask

	task automatic take_escape(input logic [7:0] c);
		dec_acc = '0;
		dec_cnt = '0;
		dec_ph = DP_NORMAL;
		case (c)
			"a": emit(8'h07, 1'b1, 1'b0);
			"b": emit(8'h08, 1'b1, 1'b0);
			"f": emit(8'h0C, 1'b1, 1'b0);
			"n": emit(8'h0A, 1'b1, 1'b0);
			"r": emit(8'h0D, 1'b1, 1'b0);
			"t": emit(8'h09, 1'b1, 1'b0);
			"v": emit(8'h0B, 1'b1, 1'b0);
			CH_NL: begin
				emit(CH_SP, 1'b1, 1'b0);
				dec_ph = DP_WS_SKIP;
			end
			"x": dec_ph = DP_HEX;
			"u": dec_ph = DP_UNI4;
			"U": dec_ph = DP_UNI8;
			default: begin
				if (c >= CH_ZERO && c <= "7") begin
					dec_acc = 32'(c - CH_ZERO);
					dec_cnt = 4'd1;
					dec_ph = DP_OCT;
				end else begin
					emit(c, 1'b1, 1'b0);
				end
			end
		endcase
	endtask

	// Work out the results of one accepted byte into step_q
	task automatic decode_byte(input bed_pkg::in_item_t req);
		logic [7:0] c;
		int h;
		int need;
		c = req.in_byte;
		h = hex_value(c);
		step_q.delete();
		case (dec_ph)
			DP_NORMAL: take_plain(c);
			DP_AFTER_BS: take_escape(c);
			DP_WS_SKIP: begin
				if (c != CH_SP && c != CH_TAB) begin
					dec_ph = DP_NORMAL;
					take_plain(c);
				end
			end
			DP_HEX: begin
				if (h >= 0) begin
					dec_acc = ((dec_acc << 4) | h) & 32'hFF;
					dec_cnt++;
					if (dec_cnt >= 2) begin
						emit(dec_acc[7:0], 1'b1, 1'b0);
						dec_ph = DP_NORMAL;
					end
				end else begin
					emit((dec_cnt != 0) ? dec_acc[7:0] : CH_X, 1'b1, 1'b0);
					dec_ph = DP_NORMAL;
					take_plain(c);
				end
			end
			DP_OCT: begin
				if (c >= CH_ZERO && c <= "7") begin
					dec_acc = (dec_acc * 8 + 32'(c - CH_ZERO)) & 32'h1FF;
					dec_cnt++;
					if (dec_cnt >= 3) begin
						emit(dec_acc[7:0], 1'b1, 1'b0);
						dec_ph = DP_NORMAL;
					end
				end else begin
					emit(dec_acc[7:0], 1'b1, 1'b0);
					dec_ph = DP_NORMAL;
					take_plain(c);
				end
			end
			DP_UNI4, DP_UNI8: begin
				need = (dec_ph == DP_UNI4) ? 4 : 8;
				if (h >= 0) begin
					dec_acc = (dec_acc << 4) | h;
					dec_cnt++;
					if (dec_cnt >= need) begin
						emit_utf8(dec_acc);
						dec_ph = DP_NORMAL;
					end
				end else begin
					emit(8'h00, 1'b0, 1'b1);
					dec_ph = DP_DROP;
				end
			end
			default: ;
		endcase

		// flush an open escape at the end of the string, then mark the end
		if (req.string_end) begin
			case (dec_ph)
				DP_AFTER_BS: emit(CH_BS, 1'b1, 1'b0);
				DP_HEX: emit((dec_cnt != 0) ? dec_acc[7:0] : CH_X, 1'b1, 1'b0);
				DP_OCT: emit(dec_acc[7:0], 1'b1, 1'b0);
				DP_UNI4, DP_UNI8: emit(8'h00, 1'b0, 1'b1);
				DP_DROP: if (step_q.size() == 0) emit(8'h00, 1'b0, 1'b1);
				default: ;
			endcase
			if (step_q.size() == 0) emit(8'h00, 1'b0, 1'b0);
			step_q[step_q.size()-1].string_done = 1'b1;
			dec_ph = DP_NORMAL;
			dec_acc = '0;
			dec_cnt = '0;
		end
		if (step_q.size() > 0) step_q[step_q.size()-1].run_end = 1'b1;
	endtask

	// ---------------------------------------------------------------- result side

	// Check each accepted result and advance the stall pattern
	always @(posedge clk) begin : rx_check
		bed_pkg::out_item_t want;
		if (pop && !empty) begin
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: unexpected result data %h valid %b run_end %b done %b err %b",
						$realtime, result.data_byte, result.byte_valid, result.run_end,
						result.string_done, result.error);
			end else begin
				want = pending.pop_front();
				results_seen++;
				if (result.data_byte !== want.data_byte || result.byte_valid !== want.byte_valid
						|| result.run_end !== want.run_end
						|| result.string_done !== want.string_done
						|| result.error !== want.error) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS) begin
						$display("%0t: result %0d mismatch", $realtime, results_seen);
						$display("  expected data %h valid %b run_end %b done %b err %b",
							want.data_byte, want.byte_valid, want.run_end,
							want.string_done, want.error);
						$display("  actual   data %h valid %b run_end %b done %b err %b",
							result.data_byte, result.byte_valid, result.run_end,
							result.string_done, result.error);
					end
				end
			end
		end
		pop <= rx_random ? ($urandom_range(0, 3) != 0) : rx_pattern[rx_pos];
		rx_pos <= rx_pos + 4'd1;
	end

	// End the run if neither side moves for too long
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("tb: failure");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// ---------------------------------------------------------------- request side

	// Offer one request, wait for it to be taken, log its expected results
	task automatic put_request(input bed_pkg::in_item_t req, input logic typed,
			input bed_pkg::out_item_t want);
		item <= req;
		push <= 1'b1;
		tx_active = 1'b1;
		@(posedge clk);
		while (full) @(posedge clk);
		decode_byte(req);
		if (typed) pending.push_back(want);
		else foreach (step_q[i]) pending.push_back(step_q[i]);
		items_sent++;
		if (tx_gaps) begin
			burst_left--;
			if (burst_left <= 0) begin
				push <= 1'b0;
				tx_active = 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
				burst_left = $urandom_range(1, 16);
			end
		end
	endtask

	// Hold the sender until every expected result is out and the pipe is quiet
	task automatic drain();
		if (tx_active) begin
			push <= 1'b0;
			tx_active = 1'b0;
		end
		while (pending.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_cfg(input logic v);
		cfg_wdata <= v;
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		esc_en = v;
		cfg_writes++;
	endtask

	task automatic add_row(input logic [7:0] b, input logic last, input logic typed,
			input bed_pkg::out_item_t want);
		stim_row_t row;
		row.req.in_byte = b;
		row.req.string_end = last;
		row.typed = typed;
		row.want = want;
		dir_rows.push_back(row);
	endtask

	function automatic logic [7:0] hex_char(logic [3:0] v);
		if (v < 10) return CH_ZERO + v;
		return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + v - 8'd10;
	endfunction

	task automatic push_hex(input logic [31:0] v, input int digits);
		for (int i = digits - 1; i >= 0; i--) string_bytes.push_back(hex_char(v[4*i +: 4]));
	endtask

	// Append one random piece of text: plain bytes, escapes or cut-short escapes
	task automatic add_token();
		logic [31:0] cp;
		int n;
		case ($urandom_range(0, 13))
			0, 1, 2, 3: string_bytes.push_back(8'($urandom_range(0, 255)));
			4: begin
				string_bytes.push_back(CH_BS);
				if ($urandom_range(0, 3) != 0)
					string_bytes.push_back(CTRL_LETTERS[8*$urandom_range(0, 6) +: 8]);
				else
					string_bytes.push_back(8'($urandom_range(0, 255)));
			end
			5: begin
				string_bytes.push_back(CH_BS);
				string_bytes.push_back(CH_BS);
			end
			6: begin
				string_bytes.push_back(CH_BS);
				string_bytes.push_back(CH_NL);
				repeat ($urandom_range(0, 3))
					string_bytes.push_back($urandom_range(0, 1) ? CH_SP : CH_TAB);
			end
			7: begin
				string_bytes.push_back(CH_BS);
				string_bytes.push_back(CH_X);
				push_hex($urandom_range(0, 255), $urandom_range(0, 2));
			end
			8: begin
				string_bytes.push_back(CH_BS);
				repeat ($urandom_range(1, 3))
					string_bytes.push_back(CH_ZERO + 8'($urandom_range(0, 7)));
			end
			9: begin
				string_bytes.push_back(CH_BS);
				string_bytes.push_back("u");
				push_hex($urandom_range(0, 16'hFFFF), 4);
			end
			10: begin
				case ($urandom_range(0, 5))
					0: cp = $urandom_range(0, 32'h7F);
					1: cp = $urandom_range(32'h80, 32'h7FF);
					2: cp = $urandom_range(32'h800, 32'hFFFF);
					3: cp = $urandom_range(32'hD800, 32'hDFFF);
					4: cp = $urandom_range(32'h10000, 32'h10FFFF);
					default: cp = $urandom_range(0, 1) ? 32'hFFFFFFFF
						: $urandom_range(32'h110000, 32'hFFFFFFFF);
				endcase
				string_bytes.push_back(CH_BS);
				string_bytes.push_back("U");
				push_hex(cp, 8);
			end
			11: begin
				// unicode escape cut short
				string_bytes.push_back(CH_BS);
				if ($urandom_range(0, 1)) begin
					string_bytes.push_back("u");
					n = $urandom_range(0, 3);
				end else begin
					string_bytes.push_back("U");
					n = $urandom_range(0, 7);
				end
				push_hex($urandom(), n);
				if ($urandom_range(0, 1)) string_bytes.push_back("G");
			end
			12: string_bytes.push_back(8'($urandom_range(8'h20, 8'h7E)));
			default: string_bytes.push_back(CH_BS);
		endcase
	endtask

	task automatic send_string(input logic leave_open);
		bed_pkg::in_item_t req;
		foreach (string_bytes[i]) begin
			req.in_byte = string_bytes[i];
			req.string_end = (i == string_bytes.size() - 1) && !leave_open;
			put_request(req, 1'b0, NO_RESULT);
		end
		strings_sent++;
	endtask

	// ---------------------------------------------------------------- sequence

	initial begin : main
		int phase_start;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_cfg(1'b1);

		// directed strings; typed results read {data, valid, run_end, done, err}
		add_row(CH_BS, 1'b0, 1'b0, NO_RESULT);
		add_row(CH_NL, 1'b0, 1'b0, NO_RESULT);
		add_row(CH_SP, 1'b0, 1'b0, NO_RESULT);
		add_row(CH_TAB, 1'b1, 1'b1, {8'h00, 4'b0110});
		add_row(CH_BS, 1'b0, 1'b0, NO_RESULT);
		add_row(CH_X, 1'b0, 1'b0, NO_RESULT);
		add_row(8'h00, 1'b0, 1'b0, NO_RESULT);
		add_row(CH_BS, 1'b0, 1'b0, NO_RESULT);
		add_row("7", 1'b0, 1'b0, NO_RESULT);
		add_row("7", 1'b0, 1'b0, NO_RESULT);
		add_row("7", 1'b0, 1'b1, {8'hFF, 4'b1100});
		add_row(CH_BS, 1'b0, 1'b0, NO_RESULT);
		add_row("u", 1'b0, 1'b0, NO_RESULT);
		add_row("Z", 1'b0, 1'b1, {8'h00, 4'b0101});
		add_row("q", 1'b1, 1'b1, {8'h00, 4'b0111});
		add_row(CH_BS, 1'b0, 1'b0, NO_RESULT);
		add_row("U", 1'b0, 1'b0, NO_RESULT);
		for (int i = 7; i >= 0; i--) add_row(BIG_CP_DIGITS[8*i +: 8], 1'b0, 1'b0, NO_RESULT);
		add_row(8'hFF, 1'b0, 1'b1, {8'hFF, 4'b1100});
		add_row(CH_BS, 1'b1, 1'b1, {CH_BS, 4'b1110});
		foreach (dir_rows[i]) put_request(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);

		// random phases, each with its own escape setting and idle pattern
		for (int p = 0; p < NUM_PHASES; p++) begin
			drain();
			write_cfg(PHASE_ESC[p]);
			tx_gaps = (p != 1);
			rx_random = (p == 1);
			case (p)
				0: rx_pattern = 16'hFFFF;
				2: rx_pattern = 16'h1111;
				default: rx_pattern = 16'hF0F3;
			endcase
			phase_start = items_sent;
			while (items_sent - phase_start < PHASE_ITEMS) begin
				string_bytes.delete();
				repeat ($urandom_range(1, 6)) add_token();
				send_string(1'b0);
			end
			// leave a hex escape open across the next register write
			if (p == 0) begin
				string_bytes = {CH_BS, CH_X, 8'h34};
				send_string(1'b1);
			end
		end

		drain();
		$display("tb: %0d bytes in %0d strings, %0d results checked, %0d mismatches",
			items_sent, strings_sent, results_seen, mismatches);
		$display("tb: %0d register writes, one of them inside an open escape", cfg_writes);
		if (mismatches == 0 && pending.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

[filelist.f]
rtl/core/bed_pkg.sv
rtl/core/bed_front.sv
rtl/core/bed_queue.sv
rtl/core/bed_back.sv
rtl/core/backslash_escape_decoder_top.sv
tb/tb_top.sv
